>>> rtl/iilp_pkg.sv
// shared types, constants and character helpers for the integer literal parser
// no dependencies
package iilp_pkg;

  localparam int VALUE_W   = 32;
  localparam int PROD_W    = VALUE_W + 5;
  localparam int OPQ_DEPTH = 4;
  localparam int OPQ_AW    = 2;
  localparam int PEND_N    = 4;

  localparam logic [VALUE_W-1:0] VAL_HALF = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] VAL_SMAX = {1'b0, {(VALUE_W-1){1'b1}}};

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [4:0] RADIX_2  = 5'd2;
  localparam logic [4:0] RADIX_8  = 5'd8;
  localparam logic [4:0] RADIX_10 = 5'd10;
  localparam logic [4:0] RADIX_16 = 5'd16;

  localparam logic [6:0] DIGIT_NONE = 7'd99;

  typedef enum logic [1:0] {
    F_LEAD,
    F_PREFIX,
    F_BODY
  } front_phase_t;

  typedef enum logic [2:0] {
    B_ZSTART,
    B_ZEROS,
    B_SKIPWS,
    B_SIGNED,
    B_HEX0,
    B_DIGITS,
    B_STOP
  } back_phase_t;

  typedef enum logic {
    OP_CHAR,
    OP_END
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] ch;
    logic [4:0] radix;
    logic       neg;
    logic       uns;
    logic       bad;
  } op_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_x(input logic [7:0] c);
    return (c == CH_LX) || (c == CH_UX);
  endfunction

  function automatic logic [6:0] digit_val(input logic [7:0] c);
    logic [7:0] r;
    r = {1'b0, DIGIT_NONE};
    if (c >= 8'h30 && c <= 8'h39) r = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h7a) r = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h5a) r = c - 8'h37;
    return r[6:0];
  endfunction

endpackage

>>> rtl/iilp_front.sv
// front end: whitespace, sign and radix prefix handling with two-character lookahead
// emits character and end operations toward the back end; uses iilp_pkg
module iilp_front
  import iilp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code,
  input  logic       last_char,
  input  logic       no_char,
  input  logic       unsigned_mode,
  output logic       q_push,
  output op_t        q_data,
  input  logic       q_full
);

  front_phase_t ph, ph_next;
  logic [7:0]   la0, la0_next, la1, la1_next;
  logic [1:0]   la_cnt, la_cnt_next;
  logic [4:0]   rad, rad_next;
  logic         neg, neg_next;
  logic         err, err_next;
  logic         in_str, in_str_next;
  logic         uns, uns_next;

  op_t          pend [PEND_N];
  logic [2:0]   pcnt;
  op_t          ops [PEND_N];
  logic [7:0]   ch_buf [PEND_N];
  logic [PEND_N-1:0] is_end;
  logic [2:0]   n;
  logic         uns_e;
  logic [4:0]   ctx_rad;
  logic         ctx_neg;
  logic         ctx_bad;
  logic         accept;

  assign full   = !((pcnt == 3'd0) || (pcnt == 3'd1 && !q_full));
  assign accept = push && !full;
  assign q_push = (pcnt != 3'd0) && !q_full;
  assign q_data = pend[0];

  always_comb begin
    ph_next     = ph;
    la0_next    = la0;
    la1_next    = la1;
    la_cnt_next = la_cnt;
    rad_next    = rad;
    neg_next    = neg;
    err_next    = err;
    in_str_next = in_str;
    uns_next    = uns;
    n           = 3'd0;
    is_end      = '0;
    for (int i = 0; i < PEND_N; i++) ch_buf[i] = 8'd0;
    uns_e   = in_str ? uns : unsigned_mode;
    ctx_rad = rad;
    ctx_neg = neg;
    ctx_bad = 1'b0;
    if (!(no_char && !last_char)) begin
      in_str_next = 1'b1;
      uns_next    = uns_e;
      if (!no_char && !err) begin
        unique case (ph)
          F_LEAD: begin
            if (is_space(char_code)) begin
              ph_next = F_LEAD;
            end else if (char_code == CH_MINUS) begin
              neg_next = 1'b1;
              ph_next  = F_BODY;
            end else if (char_code == CH_PLUS) begin
              ph_next = F_BODY;
            end else begin
              la0_next    = char_code;
              la_cnt_next = 2'd1;
              ph_next     = F_PREFIX;
            end
          end
          F_PREFIX: begin
            if (char_code == CH_HASH) begin
              if (la_cnt == 2'd1) begin
                if (la0 == CH_2) rad_next = RADIX_2;
                else if (la0 == CH_8) rad_next = RADIX_8;
                else err_next = 1'b1;
              end else begin
                if (la0 == CH_1 && la1 == CH_6) rad_next = RADIX_16;
                else err_next = 1'b1;
              end
              la0_next    = 8'd0;
              la1_next    = 8'd0;
              la_cnt_next = 2'd0;
              ph_next     = F_BODY;
            end else if (la_cnt == 2'd1) begin
              la1_next    = char_code;
              la_cnt_next = 2'd2;
            end else begin
              ch_buf[n[1:0]] = la0;
              n = n + 3'd1;
              ch_buf[n[1:0]] = la1;
              n = n + 3'd1;
              ch_buf[n[1:0]] = char_code;
              n = n + 3'd1;
              la0_next    = 8'd0;
              la1_next    = 8'd0;
              la_cnt_next = 2'd0;
              ph_next     = F_BODY;
            end
          end
          F_BODY: begin
            ch_buf[n[1:0]] = char_code;
            n = n + 3'd1;
          end
          default: ph_next = F_LEAD;
        endcase
      end
      if (last_char) begin
        if (ph_next == F_PREFIX && !err_next) begin
          ch_buf[n[1:0]] = la0_next;
          n = n + 3'd1;
          if (la_cnt_next == 2'd2) begin
            ch_buf[n[1:0]] = la1_next;
            n = n + 3'd1;
          end
        end
        ctx_bad = err_next || (ph_next == F_LEAD);
        is_end[n[1:0]] = 1'b1;
        n = n + 3'd1;
      end
      ctx_rad = rad_next;
      ctx_neg = neg_next;
      if (last_char) begin
        ph_next     = F_LEAD;
        la0_next    = 8'd0;
        la1_next    = 8'd0;
        la_cnt_next = 2'd0;
        rad_next    = RADIX_10;
        neg_next    = 1'b0;
        err_next    = 1'b0;
        in_str_next = 1'b0;
        uns_next    = 1'b0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < PEND_N; i++) begin
      ops[i].kind  = is_end[i] ? OP_END : OP_CHAR;
      ops[i].ch    = ch_buf[i];
      ops[i].radix = ctx_rad;
      ops[i].neg   = ctx_neg;
      ops[i].uns   = uns_e;
      ops[i].bad   = ctx_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph     <= F_LEAD;
      la0    <= 8'd0;
      la1    <= 8'd0;
      la_cnt <= 2'd0;
      rad    <= RADIX_10;
      neg    <= 1'b0;
      err    <= 1'b0;
      in_str <= 1'b0;
      uns    <= 1'b0;
      pcnt   <= 3'd0;
    end else if (accept) begin
      ph     <= ph_next;
      la0    <= la0_next;
      la1    <= la1_next;
      la_cnt <= la_cnt_next;
      rad    <= rad_next;
      neg    <= neg_next;
      err    <= err_next;
      in_str <= in_str_next;
      uns    <= uns_next;
      pcnt   <= n;
    end else if (q_push) begin
      pcnt <= pcnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < PEND_N; i++) pend[i] <= ops[i];
    end else if (q_push) begin
      for (int i = 0; i < PEND_N - 1; i++) pend[i] <= pend[i+1];
    end
  end

endmodule

>>> rtl/iilp_opq.sv
// short operation queue between front and back end
// uses iilp_pkg for the operation type and depth
module iilp_opq
  import iilp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  op_t  wr_data,
  output logic full_q,
  input  logic rd_en,
  output op_t  rd_data,
  output logic empty_q
);

  op_t              mem [OPQ_DEPTH];
  logic [OPQ_AW-1:0] wr_ptr, rd_ptr;
  logic [OPQ_AW:0]   count;
  logic              do_wr, do_rd;

  assign full_q  = (count == OPQ_AW'(0) + (OPQ_AW+1)'(OPQ_DEPTH));
  assign empty_q = (count == '0);
  assign do_wr   = wr_en && !full_q;
  assign do_rd   = rd_en && !empty_q;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

endmodule

>>> rtl/iilp_back.sv
// back end: zero skip, conversion state machine, accumulate and saturate
// holds the result register toward the output; uses iilp_pkg
module iilp_back
  import iilp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  op_t                op,
  input  logic               op_valid,
  output logic               op_take,
  output logic               empty,
  input  logic               pop,
  output logic [VALUE_W-1:0] value_bits,
  output logic               status
);

  back_phase_t        bph, bph_next;
  logic               berr, berr_next;
  logic               bneg, bneg_next;
  logic               ovf, ovf_next;
  logic [VALUE_W-1:0] acc, acc_next;
  logic               do_digit;
  logic [6:0]         dval;
  logic [PROD_W-1:0]  prod;
  logic               out_valid;
  logic [VALUE_W-1:0] res_value;
  logic               res_bad;
  logic [VALUE_W-1:0] fin;
  logic               nflag;
  logic               is_end;

  assign is_end  = (op.kind == OP_END);
  assign op_take = op_valid && (!is_end || !out_valid || pop);
  assign empty   = !out_valid;
  assign dval    = digit_val(op.ch);

  // phase walk for one character
  always_comb begin
    logic done;
    done      = 1'b0;
    bph_next  = bph;
    berr_next = berr;
    bneg_next = bneg;
    do_digit  = 1'b0;
    if (!berr) begin
      if (bph == B_ZSTART || bph == B_ZEROS) begin
        if (op.ch == CH_0) begin
          bph_next = B_ZEROS;
          done     = 1'b1;
        end else if (is_x(op.ch)) begin
          berr_next = 1'b1;
          done      = 1'b1;
        end else begin
          bph_next = op.neg ? B_SIGNED : B_SKIPWS;
        end
      end
      if (!done && bph_next == B_SKIPWS) begin
        if (is_space(op.ch)) begin
          done = 1'b1;
        end else if (op.ch == CH_PLUS) begin
          bph_next = B_SIGNED;
          done     = 1'b1;
        end else if (op.ch == CH_MINUS) begin
          bneg_next = 1'b1;
          bph_next  = B_SIGNED;
          done      = 1'b1;
        end else begin
          bph_next = B_SIGNED;
        end
      end
      if (!done && bph_next == B_SIGNED) begin
        if (op.radix == RADIX_16 && op.ch == CH_0) begin
          bph_next = B_HEX0;
          done     = 1'b1;
        end else begin
          bph_next = B_DIGITS;
        end
      end else if (!done && bph_next == B_HEX0) begin
        bph_next = B_DIGITS;
        if (is_x(op.ch)) done = 1'b1;
      end
      if (!done && bph_next == B_DIGITS) begin
        if (dval >= {2'b00, op.radix}) bph_next = B_STOP;
        else do_digit = 1'b1;
      end
    end
  end

  // accumulate and final value
  always_comb begin
    prod     = {5'd0, acc} * {{(PROD_W-5){1'b0}}, op.radix} + PROD_W'(dval);
    acc_next = acc;
    ovf_next = ovf;
    if (do_digit && !ovf) begin
      if (|prod[PROD_W-1:VALUE_W]) ovf_next = 1'b1;
      else acc_next = prod[VALUE_W-1:0];
    end
    nflag = op.neg || bneg;
    if (op.uns) begin
      if (ovf) fin = {VALUE_W{1'b1}};
      else fin = nflag ? (~acc + 1'b1) : acc;
    end else if (nflag) begin
      fin = (ovf || acc > VAL_HALF) ? VAL_HALF : (~acc + 1'b1);
    end else begin
      fin = (ovf || acc > VAL_SMAX) ? VAL_SMAX : acc;
    end
    res_bad   = op.bad || berr || (bph == B_ZSTART);
    res_value = '0;
    if (!res_bad && bph != B_ZEROS) begin
      if (fin == '0) res_bad = 1'b1;
      else res_value = fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bph       <= B_ZSTART;
      berr      <= 1'b0;
      bneg      <= 1'b0;
      ovf       <= 1'b0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (op_take && is_end) begin
        bph       <= B_ZSTART;
        berr      <= 1'b0;
        bneg      <= 1'b0;
        ovf       <= 1'b0;
        acc       <= '0;
        out_valid <= 1'b1;
      end else begin
        if (op_take) begin
          bph  <= bph_next;
          berr <= berr_next;
          bneg <= bneg_next;
          ovf  <= ovf_next;
          acc  <= acc_next;
        end
        if (pop && out_valid) out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_take && is_end) begin
      value_bits <= res_value;
      status     <= res_bad;
    end
  end

endmodule

>>> rtl/iec_integer_literal_parser_core.sv
// top level of the integer literal parser: front end, operation queue, back end
// depends on iilp_pkg, iilp_front, iilp_opq and iilp_back
// throughput: one item per cycle while full is low; an item that emits several operations
// (its character, replayed prefix characters, string end) holds full until only the last is left to send
// result path: front pending register, operation queue, back end result register
// reset: synchronous, clears all parse state, the queue and the result valid flag
module iec_integer_literal_parser_core
  import iilp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         char_code,
  input  logic               last_char,
  input  logic               no_char,
  input  logic               unsigned_mode,
  output logic               empty,
  input  logic               pop,
  output logic [VALUE_W-1:0] value_bits,
  output logic               status
);

  logic q_push, q_full, q_take, q_empty;
  op_t  q_wdata, q_rdata;

  iilp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .char_code     (char_code),
    .last_char     (last_char),
    .no_char       (no_char),
    .unsigned_mode (unsigned_mode),
    .q_push        (q_push),
    .q_data        (q_wdata),
    .q_full        (q_full)
  );

  iilp_opq u_opq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full_q  (q_full),
    .rd_en   (q_take),
    .rd_data (q_rdata),
    .empty_q (q_empty)
  );

  iilp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .op         (q_rdata),
    .op_valid   (!q_empty),
    .op_take    (q_take),
    .empty      (empty),
    .pop        (pop),
    .value_bits (value_bits),
    .status     (status)
  );

endmodule

>>> tb/tb_iec_integer_literal_parser_core.sv
// self-checking testbench for iec_integer_literal_parser_core: feeds literal strings one
// character per transfer and checks each parse result against a scoreboard with its own parser
// depends on iilp_pkg and the parser core
module tb_iec_integer_literal_parser_core;
  import iilp_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int ITEM_TARGET  = 1550;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 24;
  localparam longint unsigned MAG_MAX = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               status;
  } parse_result_t;

  class literal_scoreboard;
    front_phase_t  front;
    back_phase_t   back;
    logic [15:0]   held_chars;
    logic [1:0]    held_count;
    logic [4:0]    radix;
    logic          negative;
    logic          unsigned_sel;
    logic          overflow;
    logic          bad_syntax;
    logic          mid_string;
    logic [32:0]   magnitude;
    parse_result_t awaited_results[$];
    int            errors;

    function new();
      errors = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      front        = F_LEAD;
      back         = B_ZSTART;
      held_chars   = '0;
      held_count   = '0;
      radix        = RADIX_10;
      negative     = 1'b0;
      unsigned_sel = 1'b0;
      overflow     = 1'b0;
      bad_syntax   = 1'b0;
      mid_string   = 1'b0;
      magnitude    = '0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function int digit_of(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h7a) return int'(c) - 'h57;
      if (c >= 8'h41 && c <= 8'h5a) return int'(c) - 'h37;
      return 99;
    endfunction

    // strtol-style conversion of one character
    function void convert_char(logic [7:0] c);
      longint unsigned d;
      longint unsigned m;
      longint unsigned r;
      if (back == B_SKIPWS) begin
        if (is_blank(c)) return;
        if (c == CH_PLUS) begin
          back = B_SIGNED;
          return;
        end
        if (c == CH_MINUS) begin
          negative = 1'b1;
          back = B_SIGNED;
          return;
        end
        back = B_SIGNED;
      end
      if (back == B_SIGNED) begin
        if (radix == RADIX_16 && c == CH_0) begin
          back = B_HEX0;
          return;
        end
        back = B_DIGITS;
      end else if (back == B_HEX0) begin
        back = B_DIGITS;
        if (c == CH_LX || c == CH_UX) return;
      end
      if (back != B_DIGITS) return;
      d = longint'(digit_of(c));
      r = longint'(radix);
      if (d >= r) begin
        back = B_STOP;
        return;
      end
      if (overflow) return;
      m = longint'(magnitude);
      if (m > (MAG_MAX - d) / r) begin
        overflow = 1'b1;
        return;
      end
      magnitude = 33'(m * r + d);
    endfunction

    function void body_char(logic [7:0] c);
      if (bad_syntax) return;
      if (back == B_ZSTART || back == B_ZEROS) begin
        if (c == CH_0) begin
          back = B_ZEROS;
          return;
        end
        if (c == CH_LX || c == CH_UX) begin
          bad_syntax = 1'b1;
          return;
        end
        back = negative ? B_SIGNED : B_SKIPWS;
      end
      convert_char(c);
    endfunction

    function void replay_held();
      logic [1:0]  n;
      logic [15:0] la;
      n = held_count;
      la = held_chars;
      held_count = '0;
      held_chars = '0;
      front = F_BODY;
      back = B_ZSTART;
      if (n >= 2'd1) body_char(la[7:0]);
      if (n >= 2'd2) body_char(la[15:8]);
    endfunction

    function void enter_body();
      held_count = '0;
      held_chars = '0;
      front = F_BODY;
      back = B_ZSTART;
    endfunction

    function void feed(logic [7:0] c);
      case (front)
        F_LEAD: begin
          if (is_blank(c)) return;
          if (c == CH_MINUS) begin
            negative = 1'b1;
            enter_body();
          end else if (c == CH_PLUS) begin
            enter_body();
          end else begin
            held_chars = {8'h00, c};
            held_count = 2'd1;
            front = F_PREFIX;
          end
        end
        F_PREFIX: begin
          if (held_count == 2'd1) begin
            if (c == CH_HASH) begin
              if (held_chars[7:0] == CH_2) radix = RADIX_2;
              else if (held_chars[7:0] == CH_8) radix = RADIX_8;
              else bad_syntax = 1'b1;
              enter_body();
            end else begin
              held_chars[15:8] = c;
              held_count = 2'd2;
            end
          end else begin
            if (c == CH_HASH) begin
              if (held_chars[7:0] == CH_1 && held_chars[15:8] == CH_6) radix = RADIX_16;
              else bad_syntax = 1'b1;
              enter_body();
            end else begin
              replay_held();
              body_char(c);
            end
          end
        end
        default: body_char(c);
      endcase
    endfunction

    function logic [VALUE_W-1:0] saturated_value();
      logic [VALUE_W-1:0] mag;
      mag = magnitude[VALUE_W-1:0];
      if (unsigned_sel) begin
        if (overflow) return '1;
        return negative ? -mag : mag;
      end
      if (negative) begin
        if (overflow || magnitude > {1'b0, VAL_HALF}) return VAL_HALF;
        return -mag;
      end
      if (overflow || magnitude > {1'b0, VAL_SMAX}) return VAL_SMAX;
      return mag;
    endfunction

    function void note_item(logic [7:0] c, logic last, logic none, logic uns);
      parse_result_t res;
      if (none && !last) return;
      if (!mid_string) begin
        mid_string = 1'b1;
        unsigned_sel = uns;
      end
      if (!none && !bad_syntax) feed(c);
      if (!last) return;
      if (front == F_PREFIX && !bad_syntax) replay_held();
      res.value = '0;
      res.status = 1'b0;
      if (bad_syntax || front == F_LEAD || back == B_ZSTART) begin
        res.status = 1'b1;
      end else if (back != B_ZEROS) begin
        res.value = saturated_value();
        res.status = (res.value == '0);
      end
      awaited_results.push_back(res);
      clear_parse();
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [VALUE_W-1:0] value, logic stat);
      parse_result_t want;
      if (awaited_results.size() == 0) begin
        report($sformatf("result with nothing pending: value=%h status=%0b", value, stat));
        return;
      end
      want = awaited_results.pop_front();
      if (value !== want.value)
        report($sformatf("value_bits got %h want %h", value, want.value));
      if (stat !== want.status)
        report($sformatf("status got %0b want %0b", stat, want.status));
    endtask

    task flag_leftovers();
      if (awaited_results.size() != 0)
        report($sformatf("%0d results never arrived", awaited_results.size()));
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  logic [7:0]         char_code;
  logic               last_char;
  logic               no_char;
  logic               unsigned_mode;
  logic               empty;
  logic               pop;
  logic [VALUE_W-1:0] value_bits;
  logic               status;

  literal_scoreboard literal_sb;
  logic [7:0]        text_buf[$];
  int                items_sent;
  int                hold_left;
  int                cycle_count;
  bit                hold_req;
  bit                burst;
  string             boundary_texts[6] = '{"2147483647", "2147483648", "4294967295",
                                           "4294967296", "-2147483648", "-2147483649"};

  iec_integer_literal_parser_core DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .char_code(char_code),
    .last_char(last_char),
    .no_char(no_char),
    .unsigned_mode(unsigned_mode),
    .empty(empty),
    .pop(pop),
    .value_bits(value_bits),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && push && !full) literal_sb.note_item(char_code, last_char, no_char, unsigned_mode);
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) literal_sb.check_result(value_bits, status);
  end

  // result side: random pops, occasional long stalls, eager stretches and forced hold-offs
  initial begin
    int  stall_left;
    int  tick;
    int  r;
    bit  eager;
    pop = 1'b0;
    hold_left = 0;
    stall_left = 0;
    tick = 0;
    eager = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      tick++;
      if (tick % 64 == 0) eager = ($urandom_range(0, 3) == 0);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (eager) begin
        pop <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          stall_left = $urandom_range(10, 40);
          pop <= 1'b0;
        end else begin
          pop <= (r < 70);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (burst || hold_left > 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input logic [7:0] c, input logic last, input logic none,
                           input logic uns);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push <= 1'b1;
    char_code <= c;
    last_char <= last;
    no_char <= none;
    unsigned_mode <= uns;
    do @(posedge clk); while (full);
    if (last || !none) items_sent++;
  endtask

  task automatic send_text(input string s, input logic uns);
    int i;
    for (i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1, 1'b0, uns);
  endtask

  task automatic put_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  function automatic logic [7:0] digit_char(int d);
    if (d < 10) return 8'(8'h30 + d);
    return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + d - 10);
  endfunction

  function automatic logic [7:0] blank_char();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : 8'(9 + r);
  endfunction

  function automatic logic [7:0] x_char();
    return $urandom_range(0, 1) ? CH_LX : CH_UX;
  endfunction

  // mostly well-formed literals with random content, some noise strings
  task automatic make_literal();
    int base;
    int n;
    int i;
    text_buf.delete();
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 29) == 0) begin
      put_text(boundary_texts[$urandom_range(0, 5)]);
      return;
    end
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) text_buf.push_back(blank_char());
    base = 10;
    case ($urandom_range(0, 7))
      0: text_buf.push_back(CH_MINUS);
      1: text_buf.push_back(CH_PLUS);
      2: begin
        put_text("2#");
        base = 2;
      end
      3: begin
        put_text("8#");
        base = 8;
      end
      4: begin
        put_text("16#");
        base = 16;
      end
      5: begin
        repeat ($urandom_range(1, 2)) text_buf.push_back(8'(8'h30 + $urandom_range(0, 9)));
        text_buf.push_back(CH_HASH);
      end
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) text_buf.push_back(CH_0);
    if ($urandom_range(0, 15) == 0) text_buf.push_back(x_char());
    if ($urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1)) text_buf.push_back(CH_SPACE);
      if ($urandom_range(0, 1)) text_buf.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
      if (base == 16 && $urandom_range(0, 1)) begin
        text_buf.push_back(CH_0);
        text_buf.push_back(x_char());
      end
    end
    if ($urandom_range(0, 9) == 0) n = $urandom_range(8, base == 2 ? 34 : 12);
    else n = $urandom_range(0, 4);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 24) == 0) text_buf.push_back(8'($urandom_range(0, 255)));
      else text_buf.push_back(digit_char($urandom_range(0, base - 1)));
    end
    if ($urandom_range(0, 7) == 0) text_buf.push_back(8'($urandom_range(8'h21, 8'h7e)));
  endtask

  task automatic send_literal();
    bit tail_none;
    int i;
    tail_none = ($urandom_range(0, 9) == 0) || (text_buf.size() == 0);
    for (i = 0; i < text_buf.size(); i++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'($urandom_range(0, 1)));
      send_item(text_buf[i], (i == text_buf.size() - 1) && !tail_none, 1'b0,
                1'($urandom_range(0, 1)));
    end
    if (tail_none) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    bit second_hold;
    literal_sb = new();
    rst = 1'b1;
    push = 1'b0;
    char_code = '0;
    last_char = 1'b0;
    no_char = 1'b0;
    unsigned_mode = 1'b0;
    hold_req = 1'b0;
    burst = 1'b0;
    items_sent = 0;
    second_hold = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed strings
    send_item(8'h00, 1'b1, 1'b1, 1'b0);
    send_text(" \t", 1'b0);
    send_text("-", 1'b0);
    send_text("00", 1'b1);
    send_text("0X", 1'b0);
    send_text("7#", 1'b0);
    send_text("2#1", 1'b0);
    send_text("8#7z", 1'b1);
    send_text("-9", 1'b1);
    send_item(CH_PLUS, 1'b0, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1, 1'b1);
    send_item(CH_1, 1'b1, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0, 1'b1);
    send_text("16#F", 1'b0);

    hold_req = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      if (!second_hold && items_sent > ITEM_TARGET / 2) begin
        hold_req = 1'b1;
        second_hold = 1'b1;
      end
      burst = ($urandom_range(0, 4) == 0);
      make_literal();
      send_literal();
    end
    @(negedge clk);
    push <= 1'b0;

    while (literal_sb.awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    literal_sb.flag_leftovers();
    if (literal_sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

>>> sim.f
rtl/iilp_pkg.sv
rtl/iilp_front.sv
rtl/iilp_opq.sv
rtl/iilp_back.sv
rtl/iec_integer_literal_parser_core.sv
tb/tb_iec_integer_literal_parser_core.sv
